FILE: sv/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg
// shared types and constants of the wav header parser
// ----------------------------------------------------------------------------
package wavhp_pkg;

  // result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NOT_RIFF = 3'd1;
  localparam logic [2:0] ERR_NOT_WAVE = 3'd2;
  localparam logic [2:0] ERR_NO_FMT   = 3'd3;
  localparam logic [2:0] ERR_FMT_TRUNC = 3'd4;
  localparam logic [2:0] ERR_BAD_ENC  = 3'd5;
  localparam logic [2:0] ERR_BAD_SIZE = 3'd6;
  localparam logic [2:0] ERR_NO_DATA  = 3'd7;

  // chunk tags, little endian
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] MAX_BITS_U8  = 16'd8;
  localparam logic [15:0] MAX_BITS_S16 = 16'd16;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic        sample_format;
    logic [31:0] data_length;
    logic [2:0]  error_code;
    logic        last;
  } wavhp_res_t;

  typedef struct packed {
    logic done;
    logic in_data;
  } wavhp_stat_t;

endpackage

FILE: sv/wavhp_parser.sv
// ----------------------------------------------------------------------------
// wavhp_parser
// header parse state machine, one byte per enabled cycle
// ----------------------------------------------------------------------------
module wavhp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            step_byte,
  input  logic                  step_end,
  output wavhp_pkg::wavhp_res_t res,
  output logic                  res_fire,
  output wavhp_pkg::wavhp_stat_t stat
);
  import wavhp_pkg::*;

  localparam logic [3:0] PH_RIFF_TAG     = 4'd0;
  localparam logic [3:0] PH_RIFF_LEN     = 4'd1;
  localparam logic [3:0] PH_WAVE_TAG     = 4'd2;
  localparam logic [3:0] PH_FSEARCH_ID   = 4'd3;
  localparam logic [3:0] PH_FSEARCH_SIZE = 4'd4;
  localparam logic [3:0] PH_FSEARCH_SKIP = 4'd5;
  localparam logic [3:0] PH_FMT_SIZE     = 4'd6;
  localparam logic [3:0] PH_FMT_BODY     = 4'd7;
  localparam logic [3:0] PH_FMT_TAIL     = 4'd8;
  localparam logic [3:0] PH_DSEARCH_ID   = 4'd9;
  localparam logic [3:0] PH_DSEARCH_SIZE = 4'd10;
  localparam logic [3:0] PH_DSEARCH_SKIP = 4'd11;
  localparam logic [3:0] PH_DATA_SIZE    = 4'd12;
  localparam logic [3:0] PH_DATA_PASS    = 4'd13;
  localparam logic [3:0] PH_DONE         = 4'd14;

  logic [3:0]  phase_r,  phase_nxt;
  logic [1:0]  fbc_r,    fbc_nxt;
  logic [31:0] shift_r,  shift_nxt;
  logic [31:0] skip_r,   skip_nxt;
  logic [15:0] ftag_r,   ftag_nxt;
  logic [15:0] chan_r,   chan_nxt;
  logic [31:0] rate_r,   rate_nxt;
  logic [15:0] bps_r,    bps_nxt;
  logic [31:0] left_r,   left_nxt;

  logic [31:0] shift_in;
  logic        word_done;
  logic [1:0]  fbc_inc;
  logic [3:0]  pos;
  logic [31:0] skip_dec;
  logic [31:0] left_dec;
  logic        early;
  logic        live;

  function automatic logic [2:0] end_code(input logic [3:0] ph);
    logic [2:0] c;
    unique case (ph) inside
      PH_RIFF_TAG:                                    c = ERR_NOT_RIFF;
      PH_RIFF_LEN, PH_WAVE_TAG:                       c = ERR_NOT_WAVE;
      PH_FSEARCH_ID, PH_FSEARCH_SIZE, PH_FSEARCH_SKIP: c = ERR_NO_FMT;
      PH_FMT_SIZE, PH_FMT_BODY:                       c = ERR_FMT_TRUNC;
      default:                                        c = ERR_NO_DATA;
    endcase
    return c;
  endfunction

  assign shift_in  = {step_byte, shift_r[31:8]};
  assign word_done = (fbc_r == 2'd3);
  assign fbc_inc   = word_done ? 2'd0 : fbc_r + 2'd1;
  assign pos       = skip_r[3:0];
  assign skip_dec  = skip_r - 32'd1;
  assign left_dec  = left_r - 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    fbc_nxt   = fbc_r;
    shift_nxt = shift_r;
    skip_nxt  = skip_r;
    ftag_nxt  = ftag_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    bps_nxt   = bps_r;
    left_nxt  = left_r;
    res       = '0;
    res_fire  = 1'b0;
    early     = 1'b0;
    live      = 1'b1;
    if (step_en) begin
      unique case (phase_r)
        PH_RIFF_TAG, PH_WAVE_TAG: begin
          shift_nxt = shift_in;
          fbc_nxt   = fbc_inc;
          if (word_done) begin
            if (phase_r == PH_RIFF_TAG && shift_in != TAG_RIFF) begin
              early = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_NOT_RIFF;
            end else if (phase_r == PH_WAVE_TAG && shift_in != TAG_WAVE) begin
              early = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_NOT_WAVE;
            end else begin
              phase_nxt = (phase_r == PH_RIFF_TAG) ? PH_RIFF_LEN : PH_FSEARCH_ID;
            end
          end
        end
        PH_RIFF_LEN: begin
          shift_nxt = shift_in;
          fbc_nxt   = fbc_inc;
          if (word_done) phase_nxt = PH_WAVE_TAG;
        end
        PH_FSEARCH_ID: begin
          shift_nxt = shift_in;
          fbc_nxt   = fbc_inc;
          if (word_done) phase_nxt = (shift_in == TAG_FMT) ? PH_FMT_SIZE : PH_FSEARCH_SIZE;
        end
        PH_DSEARCH_ID: begin
          shift_nxt = shift_in;
          fbc_nxt   = fbc_inc;
          if (word_done) phase_nxt = (shift_in == TAG_DATA) ? PH_DATA_SIZE : PH_DSEARCH_SIZE;
        end
        PH_FSEARCH_SIZE, PH_DSEARCH_SIZE: begin
          shift_nxt = shift_in;
          fbc_nxt   = fbc_inc;
          if (word_done) begin
            skip_nxt = shift_in;
            if (shift_in == 32'd0)
              phase_nxt = (phase_r == PH_FSEARCH_SIZE) ? PH_FSEARCH_ID : PH_DSEARCH_ID;
            else
              phase_nxt = (phase_r == PH_FSEARCH_SIZE) ? PH_FSEARCH_SKIP : PH_DSEARCH_SKIP;
          end
        end
        PH_FSEARCH_SKIP, PH_DSEARCH_SKIP, PH_FMT_TAIL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0)
            phase_nxt = (phase_r == PH_FSEARCH_SKIP) ? PH_FSEARCH_ID : PH_DSEARCH_ID;
        end
        PH_FMT_SIZE: begin
          shift_nxt = shift_in;
          fbc_nxt   = fbc_inc;
          if (word_done) begin
            left_nxt  = shift_in;
            skip_nxt  = 32'd0;
            phase_nxt = PH_FMT_BODY;
          end
        end
        PH_FMT_BODY: begin
          shift_nxt = shift_in;
          skip_nxt  = {28'd0, pos} + 32'd1;
          if (pos == 4'd1) ftag_nxt = shift_in[31:16];
          if (pos == 4'd3) chan_nxt = shift_in[31:16];
          if (pos == 4'd7) rate_nxt = shift_in;
          if (pos == 4'd15) begin
            bps_nxt = shift_in[31:16];
            if (ftag_r != FMT_PCM) begin
              early = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_BAD_ENC;
            end else if (shift_in[31:16] > MAX_BITS_S16) begin
              early = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_BAD_SIZE;
            end else begin
              left_nxt = 32'd0;
              if (left_r > FMT_BODY_LEN) begin
                skip_nxt  = left_r - FMT_BODY_LEN;
                phase_nxt = PH_FMT_TAIL;
              end else begin
                skip_nxt  = 32'd0;
                phase_nxt = PH_DSEARCH_ID;
              end
            end
          end
        end
        PH_DATA_SIZE: begin
          shift_nxt = shift_in;
          fbc_nxt   = fbc_inc;
          if (word_done) begin
            early             = 1'b1;
            left_nxt          = shift_in;
            res.kind          = KIND_HDR;
            res.channels      = chan_r;
            res.sample_rate   = rate_r;
            res.sample_format = (bps_r > MAX_BITS_U8);
            res.data_length   = shift_in;
            res.last          = (shift_in == 32'd0) || step_end;
            phase_nxt         = res.last ? PH_DONE : PH_DATA_PASS;
          end
        end
        PH_DATA_PASS: begin
          early        = 1'b1;
          left_nxt     = left_dec;
          res.kind     = KIND_DATA;
          res.out_byte = step_byte;
          res.last     = (left_dec == 32'd0) || step_end;
          if (res.last) phase_nxt = PH_DONE;
        end
        default: live = 1'b0;
      endcase
      // early end of file while the header is still awaited
      if (live && !early && step_end) begin
        early          = 1'b1;
        res.kind       = KIND_ERR;
        res.error_code = end_code(phase_nxt);
      end
      res_fire = live && early;
      if (res_fire && res.kind == KIND_ERR) phase_nxt = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF_TAG;
      fbc_r   <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    skip_r  <= skip_nxt;
    ftag_r  <= ftag_nxt;
    chan_r  <= chan_nxt;
    rate_r  <= rate_nxt;
    bps_r   <= bps_nxt;
    left_r  <= left_nxt;
  end

  assign stat.done    = (phase_r == PH_DONE);
  assign stat.in_data = (phase_r == PH_DATA_PASS);

endmodule

FILE: sv/wavhp_out_reg.sv
// ----------------------------------------------------------------------------
// wavhp_out_reg
// result register of the wav header parser
// ----------------------------------------------------------------------------
module wavhp_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  load_fire,
  input  wavhp_pkg::wavhp_res_t load_res,
  input  logic                  out_ready,
  output logic                  out_valid,
  output wavhp_pkg::wavhp_res_t out_res
);
  import wavhp_pkg::*;

  logic       valid_r, valid_nxt;
  wavhp_res_t res_r;

  // load only happens when the register is empty or being drained
  assign valid_nxt = load ? load_fire : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_fire) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: sv/wav_header_parser_core.sv
// ----------------------------------------------------------------------------
// wav_header_parser_core
// riff/wave header parser with data byte pass-through
// ----------------------------------------------------------------------------
// usage
//   input channel: one file byte per request on in_byte, in file order, with
//   in_stream_end high on the final byte of the file
//   result channel: at most one result per input byte; out_kind tells a
//   header (channels, rate, format, data length), a data byte or an error
//   path: an accepted byte is held in the input register, then parse logic
//   writes its result into the result register
//   throughput: one byte per cycle, limited only by the output handshake
//   every byte, with or without a result, waits in the input register while
//   the result register is full and not being drained
//   stall: while a result waits, the input register still takes one byte;
//   further bytes wait until out_ready drains the result register
//   reset: synchronous rst_n returns the parser to the riff tag check and
//   empties both registers
//   after an error, the final data byte or end of file, all input bytes are
//   accepted and dropped until reset
// ----------------------------------------------------------------------------
module wav_header_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_channels,
  output logic [31:0] out_sample_rate,
  output logic        out_sample_format,
  output logic [31:0] out_data_length,
  output logic [2:0]  out_error_code,
  output logic        out_last
);
  import wavhp_pkg::*;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  logic        advance;
  wavhp_res_t  step_res;
  logic        step_fire;
  wavhp_stat_t stat;
  wavhp_res_t  out_res;

  // the held byte moves on when the result register is free this cycle
  assign advance      = s1_valid_r && (!out_valid || out_ready);
  assign in_ready     = !s1_valid_r || advance;
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_end_r  <= in_stream_end;
    end
  end

  // parse step, one byte per advance
  wavhp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .step_byte (s1_byte_r),
    .step_end  (s1_end_r),
    .res       (step_res),
    .res_fire  (step_fire),
    .stat      (stat)
  );

  // result register
  wavhp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .load_fire (step_fire),
    .load_res  (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_byte          = out_res.out_byte;
  assign out_channels      = out_res.channels;
  assign out_sample_rate   = out_res.sample_rate;
  assign out_sample_format = out_res.sample_format;
  assign out_data_length   = out_res.data_length;
  assign out_error_code    = out_res.error_code;
  assign out_last          = out_res.last;

  // error or final result leaves the parser finished
  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_fire && (step_res.kind == KIND_ERR || step_res.last)) |=> stat.done)
    else $error("parser not finished after final result");

  // a header without last opens the data phase
  a_hdr_data: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_fire && step_res.kind == KIND_HDR && !step_res.last) |=> stat.in_data)
    else $error("data phase not entered after header");

  // error results carry a code and never last
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ERR) |-> (!out_last && out_error_code != ERR_NONE))
    else $error("malformed error result");

  // no result leaves a finished parser
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> !step_fire)
    else $error("result after parser finished");

  // input is held back only by a waiting byte
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid && !out_ready))
    else $error("input stalled without cause");

endmodule

FILE: tb/tb_wav_header_parser_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wav_header_parser_core
// self-checking bench that feeds one generated wave file through the parser
// and checks every header, data and error result against a byte-level
// model of the riff/wave parse, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_wav_header_parser_core;
  import wavhp_pkg::*;

  // parse position of the header model
  typedef enum logic [3:0] {
    SEEK_RIFF, RIFF_LEN, SEEK_WAVE,
    HUNT_FMT_ID, HUNT_FMT_LEN, HUNT_FMT_SKIP,
    FMT_LEN, FMT_BODY, FMT_REST,
    HUNT_DATA_ID, HUNT_DATA_LEN, HUNT_DATA_SKIP,
    DATA_LEN, DATA_PASS, PARSE_DONE
  } parse_phase_t;

  // one file byte waiting to be sent
  typedef struct packed {
    logic [7:0] value;
    logic       is_end;
  } file_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        in_stream_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [15:0] out_channels;
  logic [31:0] out_sample_rate;
  logic        out_sample_format;
  logic [31:0] out_data_length;
  logic [2:0]  out_error_code;
  logic        out_last;

  wav_header_parser_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_stream_end     (in_stream_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_channels      (out_channels),
    .out_sample_rate   (out_sample_rate),
    .out_sample_format (out_sample_format),
    .out_data_length   (out_data_length),
    .out_error_code    (out_error_code),
    .out_last          (out_last)
  );

  always #4 clk = ~clk;

  // file bytes still to be sent, and results the parse model predicts
  file_byte_t file_bytes_q[$];
  wavhp_res_t expected_results_q[$];

  int          fault_count = 0;
  int          results_seen = 0;
  logic        quiet_tail = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_used = 1'b0;
  file_byte_t  next_byte;
  wavhp_res_t  want;
  wavhp_res_t  got;
  logic        bad;

  // --------------------------------------------------------------------------
  // header parse model
  // --------------------------------------------------------------------------
  parse_phase_t prs_phase = SEEK_RIFF;
  logic [2:0]   prs_cnt = '0;      // bytes of the current 32-bit field
  logic [31:0]  prs_word = '0;     // little-endian collector
  logic [31:0]  prs_skip = '0;     // bytes to skip, or offset in fmt body
  logic [15:0]  prs_tag = '0;
  logic [15:0]  prs_chan = '0;
  logic [31:0]  prs_rate = '0;
  logic [15:0]  prs_bits = '0;
  logic [31:0]  prs_left = '0;     // fmt size, later data bytes left

  // shifts one byte into the field collector, true once four are in
  function automatic logic take_word(input logic [7:0] b);
    prs_word = {b, prs_word[31:8]};
    prs_cnt  = prs_cnt + 3'd1;
    if (prs_cnt >= 3'd4) begin
      prs_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // a zero-length skip goes straight on to the next chunk id
  function automatic void arm_skip(input logic [31:0] n, input parse_phase_t skip_ph,
                                   input parse_phase_t next_ph);
    prs_skip  = n;
    prs_phase = (n == 32'd0) ? next_ph : skip_ph;
  endfunction

  function automatic wavhp_res_t parse_fault(input logic [2:0] code);
    wavhp_res_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.error_code = code;
    prs_phase = PARSE_DONE;
    return r;
  endfunction

  // advances the model by one file byte; true when a result is due
  function automatic logic parse_byte(input logic [7:0] b, input logic fin,
                                      output wavhp_res_t r);
    logic [3:0] pos;
    logic [2:0] code;
    r = '0;
    case (prs_phase)
      SEEK_RIFF: if (take_word(b)) begin
        if (prs_word != TAG_RIFF) begin
          r = parse_fault(ERR_NOT_RIFF);
          return 1'b1;
        end
        prs_phase = RIFF_LEN;
      end
      RIFF_LEN: if (take_word(b)) prs_phase = SEEK_WAVE;
      SEEK_WAVE: if (take_word(b)) begin
        if (prs_word != TAG_WAVE) begin
          r = parse_fault(ERR_NOT_WAVE);
          return 1'b1;
        end
        prs_phase = HUNT_FMT_ID;
      end
      HUNT_FMT_ID: if (take_word(b)) begin
        prs_phase = (prs_word == TAG_FMT) ? FMT_LEN : HUNT_FMT_LEN;
      end
      HUNT_FMT_LEN: if (take_word(b)) arm_skip(prs_word, HUNT_FMT_SKIP, HUNT_FMT_ID);
      HUNT_FMT_SKIP: begin
        prs_skip = prs_skip - 32'd1;
        if (prs_skip == 32'd0) prs_phase = HUNT_FMT_ID;
      end
      FMT_LEN: if (take_word(b)) begin
        prs_left  = prs_word;
        prs_skip  = '0;
        prs_phase = FMT_BODY;
      end
      FMT_BODY: begin
        pos = prs_skip[3:0];
        prs_word = {b, prs_word[31:8]};
        if (pos == 4'd1) prs_tag = prs_word[31:16];
        else if (pos == 4'd3) prs_chan = prs_word[31:16];
        else if (pos == 4'd7) prs_rate = prs_word;
        prs_skip = {28'd0, pos} + 32'd1;
        if (pos == 4'd15) begin
          prs_bits = prs_word[31:16];
          // encoding is checked ahead of sample size
          if (prs_tag != FMT_PCM) begin
            r = parse_fault(ERR_BAD_ENC);
            return 1'b1;
          end
          if (prs_bits > MAX_BITS_S16) begin
            r = parse_fault(ERR_BAD_SIZE);
            return 1'b1;
          end
          // a short fmt size skips nothing
          arm_skip((prs_left > FMT_BODY_LEN) ? prs_left - FMT_BODY_LEN : 32'd0,
                   FMT_REST, HUNT_DATA_ID);
          prs_left = '0;
        end
      end
      FMT_REST: begin
        prs_skip = prs_skip - 32'd1;
        if (prs_skip == 32'd0) prs_phase = HUNT_DATA_ID;
      end
      HUNT_DATA_ID: if (take_word(b)) begin
        prs_phase = (prs_word == TAG_DATA) ? DATA_LEN : HUNT_DATA_LEN;
      end
      HUNT_DATA_LEN: if (take_word(b)) arm_skip(prs_word, HUNT_DATA_SKIP, HUNT_DATA_ID);
      HUNT_DATA_SKIP: begin
        prs_skip = prs_skip - 32'd1;
        if (prs_skip == 32'd0) prs_phase = HUNT_DATA_ID;
      end
      DATA_LEN: if (take_word(b)) begin
        prs_left = prs_word;
        r.kind = KIND_HDR;
        r.channels = prs_chan;
        r.sample_rate = prs_rate;
        r.sample_format = (prs_bits <= MAX_BITS_U8) ? 1'b0 : 1'b1;
        r.data_length = prs_left;
        if (prs_left == 32'd0 || fin) begin
          r.last = 1'b1;
          prs_phase = PARSE_DONE;
        end else begin
          prs_phase = DATA_PASS;
        end
        return 1'b1;
      end
      DATA_PASS: begin
        r.kind = KIND_DATA;
        r.out_byte = b;
        prs_left = prs_left - 32'd1;
        if (prs_left == 32'd0 || fin) begin
          r.last = 1'b1;
          prs_phase = PARSE_DONE;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
    // end of file while the header is still open
    if (fin) begin
      case (prs_phase)
        SEEK_RIFF: code = ERR_NOT_RIFF;
        RIFF_LEN, SEEK_WAVE: code = ERR_NOT_WAVE;
        HUNT_FMT_ID, HUNT_FMT_LEN, HUNT_FMT_SKIP: code = ERR_NO_FMT;
        FMT_LEN, FMT_BODY: code = ERR_FMT_TRUNC;
        default: code = ERR_NO_DATA;
      endcase
      r = parse_fault(code);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // file builder
  // --------------------------------------------------------------------------
  function automatic void queue_byte(input logic [7:0] b, input logic fin = 1'b0);
    file_byte_t fb;
    fb.value  = b;
    fb.is_end = fin;
    file_bytes_q.push_back(fb);
  endfunction

  // 32-bit value, little endian
  function automatic void queue_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) queue_byte(w[8*i +: 8]);
  endfunction

  function automatic void queue_half(input logic [15:0] h);
    queue_byte(h[7:0]);
    queue_byte(h[15:8]);
  endfunction

  // chunk that the parser is meant to skip over by its size
  function automatic void queue_chunk(input logic [31:0] id, input int unsigned n);
    queue_word(id);
    queue_word(n);
    for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
  endfunction

  // foreign chunk id: now and then the other known tag, else anything but avoid
  function automatic logic [31:0] junk_tag(input logic [31:0] avoid,
                                           input logic [31:0] alt);
    logic [31:0] t;
    if ($urandom_range(0, 3) == 0) return alt;
    do t = $urandom(); while (t == avoid);
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // request driver: one file byte per request, random gaps between requests
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      // no idling once the file is nearly through
      quiet_tail <= (file_bytes_q.size() < 120);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (file_bytes_q.size() != 0) begin
          next_byte = file_bytes_q.pop_front();
          in_valid      <= 1'b1;
          in_byte       <= next_byte.value;
          in_stream_end <= next_byte.is_end;
          if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result receiver: random stall bursts plus one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
      // this cycle starts a stall burst of random length
      stall_left <= $urandom_range(0, 13);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0);
    end
  end

  // long hold-off in mid data, so the result register fills and the input stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && results_seen >= 200) begin
      hold_left <= 150;
      hold_used <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on each accepted byte, then check each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (parse_byte(in_byte, in_stream_end, want)) expected_results_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        got = {out_kind, out_byte, out_channels, out_sample_rate, out_sample_format,
               out_data_length, out_error_code, out_last};
        if (expected_results_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result: kind %0d byte %h err %0d last %0d",
                     got.kind, got.out_byte, got.error_code, got.last);
        end else begin
          want = expected_results_q.pop_front();
          bad = (got.kind !== want.kind) || (got.out_byte !== want.out_byte) ||
                (got.channels !== want.channels) ||
                (got.sample_rate !== want.sample_rate) ||
                (got.sample_format !== want.sample_format) ||
                (got.data_length !== want.data_length) ||
                (got.error_code !== want.error_code) || (got.last !== want.last);
          if (bad) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"mismatch (exp/got): kind %0d/%0d byte %h/%h ch %h/%h",
                        " rate %h/%h fmt %0d/%0d len %h/%h err %0d/%0d last %0d/%0d"},
                       want.kind, got.kind, want.out_byte, got.out_byte,
                       want.channels, got.channels, want.sample_rate, got.sample_rate,
                       want.sample_format, got.sample_format,
                       want.data_length, got.data_length,
                       want.error_code, got.error_code, want.last, got.last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus: one wave file, header shaped at random, then a long data chunk
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n_junk;
    int unsigned fmt_mode;
    int unsigned fmt_size;
    int unsigned n_data;
    int unsigned end_mode;
    logic [31:0] data_len;
    logic [15:0] chan_v;
    logic [31:0] rate_v;
    logic [15:0] bits_v;

    // riff preamble
    queue_word(TAG_RIFF);
    queue_word($urandom());
    queue_word(TAG_WAVE);

    // zero-size chunk first, then a few foreign chunks before fmt
    queue_chunk(junk_tag(TAG_FMT, TAG_DATA), 0);
    n_junk = $urandom_range(0, 3);
    for (int i = 0; i < n_junk; i++)
      queue_chunk(junk_tag(TAG_FMT, TAG_DATA), $urandom_range(0, 12));

    // fmt chunk: exact, short or with a tail to skip
    fmt_mode = $urandom_range(0, 2);
    if (fmt_mode == 0) fmt_size = FMT_BODY_LEN;
    else if (fmt_mode == 1) fmt_size = $urandom_range(0, 15);
    else fmt_size = $urandom_range(17, 28);
    case ($urandom_range(0, 2))
      0: chan_v = 16'h0000;
      1: chan_v = 16'hFFFF;
      default: chan_v = 16'($urandom());
    endcase
    case ($urandom_range(0, 2))
      0: rate_v = 32'h0000_0000;
      1: rate_v = 32'hFFFF_FFFF;
      default: rate_v = $urandom();
    endcase
    case ($urandom_range(0, 4))
      0: bits_v = 16'd0;
      1: bits_v = MAX_BITS_U8;
      2: bits_v = MAX_BITS_U8 + 16'd1;
      3: bits_v = MAX_BITS_S16;
      default: bits_v = 16'($urandom_range(0, 16));
    endcase
    queue_word(TAG_FMT);
    queue_word(fmt_size);
    queue_half(FMT_PCM);
    queue_half(chan_v);
    queue_word(rate_v);
    queue_word($urandom());            // byte rate, not used
    queue_half(16'($urandom()));       // block align, not used
    queue_half(bits_v);
    for (int i = 16; i < fmt_size; i++) queue_byte(8'($urandom_range(0, 255)));

    // foreign chunks ahead of data, sometimes a second fmt id among them
    if ($urandom_range(0, 1) == 0) queue_chunk(junk_tag(TAG_DATA, TAG_FMT), 0);
    n_junk = $urandom_range(0, 3);
    for (int i = 0; i < n_junk; i++)
      queue_chunk(junk_tag(TAG_DATA, TAG_FMT), $urandom_range(0, 12));

    // data chunk: ends on its length, or the file ends early inside it
    n_data   = $urandom_range(1400, 1500);
    end_mode = $urandom_range(0, 2);
    if (end_mode == 0) data_len = n_data;
    else if (end_mode == 1) data_len = n_data + $urandom_range(1, 1000);
    else data_len = 32'hFFFF_FFFF;
    queue_word(TAG_DATA);
    queue_word(data_len);

    // byte extremes first, then random bytes
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    queue_byte(8'h55);
    queue_byte(8'hAA);
    for (int i = 6; i < n_data - 1; i++) queue_byte(8'($urandom_range(0, 255)));
    queue_byte(8'($urandom_range(0, 255)),
               (end_mode == 0) ? 1'($urandom_range(0, 1)) : 1'b1);

    // trailing bytes the parser has to drop
    for (int i = 0; i < 16; i++)
      queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // every request taken, every result in, then a wait for strays
    while (file_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fault_count == 0) begin
      $display("wav_header_parser_core verification clean");
    end else begin
      $display("wav_header_parser_core verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("wav_header_parser_core verification failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/wavhp_pkg.sv
sv/wavhp_parser.sv
sv/wavhp_out_reg.sv
sv/wav_header_parser_core.sv
tb/tb_wav_header_parser_core.sv
